// ===== rtl/core/rfdd_pkg.sv =====
// Package for the ring FIFO with chunked drain.
// Holds buffer geometry, command codes and register map. No dependencies.
package rfdd_pkg;

  localparam int DEPTH   = 1024;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int LEN_W   = IDX_W + 1;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 32;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;
  localparam int FUNC_W  = 3;

  localparam logic [FUNC_W-1:0] FUNC_WRITE    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ERROR    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FETCH    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DRAIN    = 3'd5;

  localparam logic REG_ATTACHED = 1'b0;
  localparam logic REG_CHUNK    = 1'b1;

  localparam logic [LEN_W-1:0] CHUNK_RESET = LEN_W'(256);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;

endpackage

// ===== rtl/core/rfdd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ring_fifo_dma_chunk_drain.sv =====
// Ring FIFO of bytes drained in linear chunks; top level.
// Uses rfdd_pkg and rfdd_ram (byte store).
// The result strobe done rises in the cycle after start is taken.
// Throughput: one command per clock; busy stays low, the store has one write and one read port.
// Reset clears indices, in-flight length and counters, detaches the link and sets chunk limit 256.
// Store contents stay undefined until written; results cannot be stalled by the receiver.
module ring_fifo_dma_chunk_drain (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rfdd_pkg::FUNC_W-1:0]       func,
  input  logic [rfdd_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              message_end,
  input  logic [rfdd_pkg::IDX_W-1:0]        fetch_offset,
  output logic                              done,
  output logic                              accepted,
  output logic                              start_valid,
  output logic [rfdd_pkg::IDX_W-1:0]        start_offset,
  output logic [rfdd_pkg::LEN_W-1:0]        start_length,
  output logic                              byte_valid,
  output logic [rfdd_pkg::BYTE_W-1:0]       byte_out,
  output logic [rfdd_pkg::IDX_W-1:0]        fill_count,
  output logic                              busy_res,
  output logic [rfdd_pkg::CNT_W-1:0]        dropped_total,
  output logic [rfdd_pkg::CNT_W-1:0]        error_total,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rfdd_pkg::PADDR_W-1:0]      paddr,
  input  logic [rfdd_pkg::DATA_W-1:0]       pwdata,
  output logic [rfdd_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  rfdd_pkg::idx_t                widx, widx_next;
  rfdd_pkg::idx_t                ridx, ridx_next;
  rfdd_pkg::len_t                infl, infl_next;
  logic [rfdd_pkg::CNT_W-1:0]    drops, drops_next;
  logic [rfdd_pkg::CNT_W-1:0]    errs, errs_next;
  logic                          attached;
  rfdd_pkg::len_t                chunk_limit;

  logic                          accept;
  logic                          cfg_wr;
  logic                          ram_we;
  rfdd_pkg::idx_t                ram_raddr;
  logic [rfdd_pkg::BYTE_W-1:0]   ram_rdata;
  rfdd_pkg::idx_t                fill;
  rfdd_pkg::idx_t                ridx_adv;

  logic                          acc_c, sv_c, bv_c;
  rfdd_pkg::idx_t                so_c;
  rfdd_pkg::len_t                sl_c;

  logic                          acc_q, sv_q, bv_q;
  rfdd_pkg::idx_t                so_q;
  rfdd_pkg::len_t                sl_q;

  function automatic rfdd_pkg::len_t chunk_len(rfdd_pkg::idx_t w, rfdd_pkg::idx_t r,
                                               rfdd_pkg::len_t lim);
    rfdd_pkg::len_t n;
    rfdd_pkg::len_t cap;
    if (w > r) begin
      n = {1'b0, w - r};
    end else begin
      n = rfdd_pkg::LEN_W'(rfdd_pkg::DEPTH) - {1'b0, r};
    end
    cap = (lim == '0) ? rfdd_pkg::LEN_W'(1) : lim;
    return (n > cap) ? cap : n;
  endfunction

  assign busy     = 1'b0;
  assign pready   = 1'b1;
  assign accept   = start && !busy;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign fill     = widx - ridx;
  assign ridx_adv = ridx + infl[rfdd_pkg::IDX_W-1:0];

  assign ram_raddr = (func == rfdd_pkg::FUNC_FETCH) ? fetch_offset : ridx;

  always_comb begin
    prdata = '0;
    if (paddr[2] == rfdd_pkg::REG_CHUNK) begin
      prdata[rfdd_pkg::LEN_W-1:0] = chunk_limit;
    end else begin
      prdata[0] = attached;
    end
  end

  always_comb begin
    widx_next  = widx;
    ridx_next  = ridx;
    infl_next  = infl;
    drops_next = drops;
    errs_next  = errs;
    acc_c      = 1'b0;
    sv_c       = 1'b0;
    so_c       = '0;
    sl_c       = '0;
    bv_c       = 1'b0;
    ram_we     = 1'b0;
    case (func)
      rfdd_pkg::FUNC_WRITE: begin
        if (fill < rfdd_pkg::IDX_W'(rfdd_pkg::DEPTH - 1)) begin
          ram_we    = accept;
          widx_next = widx + 1'b1;
          acc_c     = 1'b1;
        end else begin
          drops_next = drops + 1'b1;
        end
      end
      rfdd_pkg::FUNC_FLUSH: begin
        if (attached && infl == '0 && widx != ridx) begin
          sv_c      = 1'b1;
          so_c      = ridx;
          sl_c      = chunk_len(widx, ridx, chunk_limit);
          infl_next = sl_c;
        end
      end
      rfdd_pkg::FUNC_COMPLETE: begin
        if (infl != '0) begin
          ridx_next = ridx_adv;
          infl_next = '0;
          if (attached && widx != ridx_adv) begin
            sv_c      = 1'b1;
            so_c      = ridx_adv;
            sl_c      = chunk_len(widx, ridx_adv, chunk_limit);
            infl_next = sl_c;
          end
        end
      end
      rfdd_pkg::FUNC_ERROR: begin
        errs_next = errs + 1'b1;
        infl_next = '0;
      end
      rfdd_pkg::FUNC_FETCH: begin
        bv_c = 1'b1;
      end
      rfdd_pkg::FUNC_DRAIN: begin
        if (attached && widx != ridx) begin
          infl_next = '0;
          bv_c      = 1'b1;
          ridx_next = ridx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  rfdd_ram #(
    .WIDTH(rfdd_pkg::BYTE_W),
    .DEPTH(rfdd_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(widx),
    .wdata(data_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      widx        <= '0;
      ridx        <= '0;
      infl        <= '0;
      drops       <= '0;
      errs        <= '0;
      attached    <= 1'b0;
      chunk_limit <= rfdd_pkg::CHUNK_RESET;
      done        <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        widx  <= widx_next;
        ridx  <= ridx_next;
        drops <= drops_next;
        errs  <= errs_next;
      end
      if (cfg_wr && paddr[2] == rfdd_pkg::REG_ATTACHED) begin
        infl <= '0;
      end else if (accept) begin
        infl <= infl_next;
      end
      if (cfg_wr) begin
        if (paddr[2] == rfdd_pkg::REG_ATTACHED) begin
          attached <= pwdata[0];
        end else begin
          chunk_limit <= pwdata[rfdd_pkg::LEN_W-1:0];
        end
      end
    end
  end

  // hold result payload for the strobe cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_q <= acc_c;
      sv_q  <= sv_c;
      so_q  <= so_c;
      sl_q  <= sl_c;
      bv_q  <= bv_c;
    end
  end

  assign accepted      = acc_q;
  assign start_valid   = sv_q;
  assign start_offset  = so_q;
  assign start_length  = sl_q;
  assign byte_valid    = bv_q;
  assign byte_out      = bv_q ? ram_rdata : '0;
  assign fill_count    = fill;
  assign busy_res      = (infl != '0);
  assign dropped_total = drops;
  assign error_total   = errs;

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept && !rst))
    else $error("result strobe does not follow the accepted command");

  a_start_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && start_valid) |-> (start_length != '0))
    else $error("issued transfer has zero length");

  a_start_len_cap: assert property (@(posedge clk) disable iff (rst)
    (done && start_valid) |-> (start_length <= rfdd_pkg::LEN_W'(rfdd_pkg::DEPTH)))
    else $error("issued transfer exceeds buffer depth");

  a_byte_excl: assert property (@(posedge clk) disable iff (rst)
    (done && byte_valid) |-> (!start_valid && !accepted))
    else $error("byte read result mixed with transfer or write result");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ring_fifo_dma_chunk_drain: queued commands, APB register
// setup, a cycle-accurate FIFO/transfer predictor and a result checker. Needs rfdd_pkg.
module testbench;
  import rfdd_pkg::*;

  localparam int LIMIT = 200000;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [BYTE_W-1:0] data;
    logic              last;
    idx_t              offset;
  } cmd_t;

  typedef struct packed {
    logic              acc;
    logic              sv;
    idx_t              so;
    len_t              sl;
    logic              bv;
    logic [BYTE_W-1:0] bo;
    idx_t              fill;
    logic              inflight;
    logic [CNT_W-1:0]  drops;
    logic [CNT_W-1:0]  errs;
  } status_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] func = '0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic message_end = 1'b0;
  idx_t fetch_offset = '0;
  logic done;
  logic accepted;
  logic start_valid;
  idx_t start_offset;
  len_t start_length;
  logic byte_valid;
  logic [BYTE_W-1:0] byte_out;
  idx_t fill_count;
  logic busy_res;
  logic [CNT_W-1:0] dropped_total;
  logic [CNT_W-1:0] error_total;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ring_fifo_dma_chunk_drain dut (.*);

  cmd_t    pending_q[$];
  status_t status_q[$];
  int      sender_idle_pct = 0;
  int      fault_count = 0;
  int      cycle_count = 0;
  int      n_cmds = 0;
  int      n_results = 0;
  int      n_chunks = 0;
  int      n_bytes_out = 0;

  // FIFO shadow state
  logic [BYTE_W-1:0] m_store [DEPTH];
  logic              m_written [DEPTH];
  int                m_written_cnt = 0;
  idx_t              m_wr = '0;
  idx_t              m_rd = '0;
  len_t              m_inflight = '0;
  logic [CNT_W-1:0]  m_drops = '0;
  logic [CNT_W-1:0]  m_errs = '0;
  logic              m_attached = 1'b0;
  len_t              m_chunk = CHUNK_RESET;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) m_written[i] = 1'b0;
  end

  task automatic log_fault(string msg);
    fault_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      log_fault($sformatf("result %0d %s: got 0x%0h, want 0x%0h", n_results, name, got, want));
  endtask

  function automatic idx_t fill_now();
    return m_wr - m_rd;
  endfunction

  function automatic logic open_chunk(output idx_t off, output len_t len);
    len_t cap;
    off = '0;
    len = '0;
    if (!m_attached || m_inflight != '0 || m_wr == m_rd) return 1'b0;
    if (m_wr > m_rd) len = len_t'(m_wr - m_rd);
    else len = len_t'(DEPTH) - len_t'(m_rd);
    cap = (m_chunk == '0) ? len_t'(1) : m_chunk;
    if (len > cap) len = cap;
    m_inflight = len;
    off = m_rd;
    return 1'b1;
  endfunction

  function automatic status_t apply_cmd(cmd_t c);
    status_t r;
    idx_t    off;
    len_t    len;
    r = '0;
    off = '0;
    len = '0;
    case (c.op)
      FUNC_WRITE: begin
        if (fill_now() < idx_t'(DEPTH - 1)) begin
          m_store[m_wr] = c.data;
          if (!m_written[m_wr]) m_written_cnt++;
          m_written[m_wr] = 1'b1;
          m_wr = m_wr + 1'b1;
          r.acc = 1'b1;
        end else begin
          m_drops = m_drops + 1'b1;
        end
      end
      FUNC_FLUSH: r.sv = open_chunk(off, len);
      FUNC_COMPLETE: begin
        if (m_inflight != '0) begin
          m_rd = m_rd + m_inflight[IDX_W-1:0];
          m_inflight = '0;
          r.sv = open_chunk(off, len);
        end
      end
      FUNC_ERROR: begin
        m_errs = m_errs + 1'b1;
        m_inflight = '0;
      end
      FUNC_FETCH: begin
        r.bv = 1'b1;
        r.bo = m_store[c.offset];
      end
      FUNC_DRAIN: begin
        if (m_attached && m_wr != m_rd) begin
          m_inflight = '0;
          r.bv = 1'b1;
          r.bo = m_store[m_rd];
          m_rd = m_rd + 1'b1;
        end
      end
      default: ;
    endcase
    if (r.sv) begin
      r.so = off;
      r.sl = len;
    end
    r.fill = fill_now();
    r.inflight = m_inflight != '0;
    r.drops = m_drops;
    r.errs = m_errs;
    return r;
  endfunction

  // Driver: take a transfer when start meets a low busy, then present the next command.
  always @(posedge clk) begin : drive_proc
    cmd_t    nxt;
    status_t st;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        st = apply_cmd(pending_q.pop_front());
        status_q.push_back(st);
        n_cmds++;
        if (st.sv) n_chunks++;
        if (st.bv) n_bytes_out++;
      end
      if (pending_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        nxt = pending_q[0];
        start <= 1'b1;
        func <= nxt.op;
        data_byte <= nxt.data;
        message_end <= nxt.last;
        fetch_offset <= nxt.offset;
      end else begin
        start <= 1'b0;
        func <= FUNC_W'($urandom);
        data_byte <= BYTE_W'($urandom);
        message_end <= 1'($urandom);
        fetch_offset <= idx_t'($urandom);
      end
    end
  end

  // Monitor: every strobed result pairs with the oldest prediction.
  always @(posedge clk) begin : check_proc
    status_t got;
    status_t want;
    if (!rst && done) begin
      got = '{accepted, start_valid, start_offset, start_length, byte_valid, byte_out,
              fill_count, busy_res, dropped_total, error_total};
      if (status_q.size() == 0) begin
        log_fault("result strobe with no command outstanding");
      end else begin
        want = status_q.pop_front();
        check_field("accepted", got.acc, want.acc);
        check_field("start_valid", got.sv, want.sv);
        check_field("start_offset", got.so, want.so);
        check_field("start_length", got.sl, want.sl);
        check_field("byte_valid", got.bv, want.bv);
        check_field("byte_out", got.bo, want.bo);
        check_field("fill_count", got.fill, want.fill);
        check_field("busy_res", got.inflight, want.inflight);
        check_field("dropped_total", got.drops, want.drops);
        check_field("error_total", got.errs, want.errs);
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic queue_cmd(logic [FUNC_W-1:0] op, logic [BYTE_W-1:0] data, logic last,
                           idx_t offset);
    while (pending_q.size() >= 4) @(posedge clk);
    pending_q.push_back('{op, data, last, offset});
  endtask

  task automatic queue_any(logic [FUNC_W-1:0] op);
    queue_cmd(op, BYTE_W'($urandom), 1'($urandom), idx_t'($urandom));
  endtask

  // Only entries already written may be fetched.
  function automatic idx_t pick_written();
    idx_t o;
    do o = idx_t'($urandom); while (!m_written[o]);
    return o;
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (pending_q.size() != 0 || start || status_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ATTACHED) begin
      m_attached = value[0];
      m_inflight = '0;
    end else begin
      m_chunk = value[LEN_W-1:0];
    end
  endtask

  task automatic run_random(int count);
    int made;
    int sel;
    int len;
    made = 0;
    while (made < count) begin
      sel = $urandom_range(99, 0);
      if (sel < 38) begin
        len = $urandom_range(24, 1);
        for (int i = 0; i < len; i++)
          queue_cmd(FUNC_WRITE, BYTE_W'($urandom), i == len - 1, idx_t'($urandom));
        made += len;
      end else if (sel < 58) begin
        queue_any(FUNC_FLUSH);
        len = $urandom_range(3, 0);
        for (int i = 0; i < len; i++)
          queue_cmd(FUNC_WRITE, BYTE_W'($urandom), i == len - 1, idx_t'($urandom));
        queue_any(FUNC_COMPLETE);
        made += len + 2;
      end else if (sel < 68) begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++) queue_any(FUNC_DRAIN);
        made += len;
      end else if (sel < 78) begin
        if (m_written_cnt != 0) begin
          len = $urandom_range(3, 1);
          for (int i = 0; i < len; i++)
            queue_cmd(FUNC_FETCH, BYTE_W'($urandom), 1'($urandom), pick_written());
          made += len;
        end
      end else if (sel < 84) begin
        queue_any(FUNC_ERROR);
        made++;
      end else if (sel < 90) begin
        queue_any(($urandom_range(1, 0) != 0) ? FUNC_COMPLETE : FUNC_FLUSH);
        made++;
      end else if (sel < 96) begin
        queue_any(($urandom_range(1, 0) != 0) ? FUNC_SPARE_LO : FUNC_SPARE_HI);
        made++;
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 17;

    // detached, default chunk limit
    queue_any(FUNC_FLUSH);
    queue_any(FUNC_DRAIN);
    queue_any(FUNC_COMPLETE);
    queue_any(FUNC_ERROR);
    queue_any(FUNC_SPARE_LO);
    queue_any(FUNC_SPARE_HI);
    queue_cmd(FUNC_WRITE, 8'h00, 1'b0, '1);
    queue_cmd(FUNC_WRITE, 8'hFF, 1'b0, '0);
    queue_cmd(FUNC_WRITE, 8'hA5, 1'b1, '1);
    queue_cmd(FUNC_FETCH, 8'hFF, 1'b1, idx_t'(0));
    queue_cmd(FUNC_FETCH, 8'h00, 1'b0, idx_t'(2));
    queue_any(FUNC_FLUSH);
    queue_any(FUNC_DRAIN);
    wait_drained();

    // attached, one byte per transfer
    write_reg(REG_ATTACHED, 32'd1);
    write_reg(REG_CHUNK, 32'd1);
    queue_any(FUNC_FLUSH);
    queue_any(FUNC_FLUSH);
    queue_any(FUNC_COMPLETE);
    queue_any(FUNC_ERROR);
    queue_any(FUNC_FLUSH);
    wait_drained();
    // rebind with a transfer in flight
    write_reg(REG_ATTACHED, 32'd1);
    queue_any(FUNC_FLUSH);
    queue_any(FUNC_DRAIN);
    queue_any(FUNC_COMPLETE);
    queue_any(FUNC_DRAIN);
    queue_any(FUNC_DRAIN);
    queue_any(FUNC_FLUSH);
    queue_any(FUNC_FLUSH);
    wait_drained();
    write_reg(REG_ATTACHED, 32'd0);

    // fill past full while detached, then drain across the wrap point
    write_reg(REG_CHUNK, 32'd1024);
    for (i = 0; i < DEPTH + 2; i++)
      queue_cmd(FUNC_WRITE, BYTE_W'($urandom), 1'($urandom), idx_t'($urandom));
    queue_any(FUNC_FLUSH);
    queue_any(FUNC_DRAIN);
    queue_cmd(FUNC_FETCH, 8'h00, 1'b0, '1);
    queue_cmd(FUNC_FETCH, 8'hFF, 1'b1, '0);
    wait_drained();
    write_reg(REG_ATTACHED, 32'd1);
    queue_any(FUNC_FLUSH);
    queue_any(FUNC_COMPLETE);
    queue_any(FUNC_COMPLETE);
    queue_any(FUNC_COMPLETE);
    run_random(190);

    wait_drained();
    sender_idle_pct = 55;
    write_reg(REG_CHUNK, DATA_W'($urandom_range(64, 2)));
    run_random(180);

    wait_drained();
    sender_idle_pct = 0;
    write_reg(REG_CHUNK, 32'd1);
    run_random(180);

    while (pending_q.size() != 0 || start) @(posedge clk);
    for (i = 0; i < 50 && status_q.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    while (status_q.size() != 0) begin
      void'(status_q.pop_front());
      log_fault("command never produced its result");
    end

    $display("Ran %0d commands and checked %0d results over three sender idle profiles.",
             n_cmds, n_results);
    $display("Saw %0d transfers issued, %0d bytes read back, %0d drops, %0d errors.",
             n_chunks, n_bytes_out, m_drops, m_errs);
    if (fault_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
